// ===== hdl/lottery_time_slice_scheduler_macros.svh =====
// ---------------------------------------------------------------------------
// Lottery time-slice scheduler assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef LOTTERY_TIME_SLICE_SCHEDULER_MACROS_SVH
`define LOTTERY_TIME_SLICE_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lts assertion failed");
// next-cycle implication
`define LTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lts assertion failed");
`else
`define LTS_ASSERT_NOW(label, clk, rst, ante, cons)
`define LTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/lts_pkg.sv =====
// ---------------------------------------------------------------------------
// Lottery scheduler package
// Shared codes, field widths and controller/datapath link types.
// ---------------------------------------------------------------------------
package lts_pkg;

   localparam int SLOT_LIMIT = 8;   // slots addressable by the 3-bit slot field
   localparam int TICKET_W   = 7;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   localparam logic [2:0] ST_LOADED    = 3'd0;
   localparam logic [2:0] ST_SLICE_RUN = 3'd1;
   localparam logic [2:0] ST_FINISHED  = 3'd2;
   localparam logic [2:0] ST_WIN_DONE  = 3'd3;
   localparam logic [2:0] ST_NO_WINNER = 3'd4;

   localparam logic REG_TIME_SLICE    = 1'b0;
   localparam logic REG_PROCESS_COUNT = 1'b1;

   typedef struct packed {
      logic accept;
      logic walk_step;
      logic no_winner;
      logic charge;
      logic calc_turn;
      logic calc_wait;
      logic scan_step;
      logic scan_jump;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic item_draw;
      logic ptr_end;
      logic walk_hit;
      logic win_finished;
      logic finishing;
      logic slot_pending;
   } sts_type;

endpackage

// ===== hdl/lts_req_if.sv =====
// ---------------------------------------------------------------------------
// Lottery scheduler request channel
// Valid/ready channel carrying one load or draw word.
// ---------------------------------------------------------------------------
interface lts_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [2:0]  slot;
   logic [15:0] arrive_at;
   logic [15:0] run_length;
   logic [6:0]  tickets;
   logic [6:0]  draw;

   modport source (output valid, opcode, slot, arrive_at, run_length, tickets, draw,
                   input ready);
   modport sink   (input valid, opcode, slot, arrive_at, run_length, tickets, draw,
                   output ready);
endinterface

// ===== hdl/lts_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Lottery scheduler response channel
// Valid/ready channel carrying one result word per request.
// ---------------------------------------------------------------------------
interface lts_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         winner;
   logic [2:0]         status;
   logic [31:0]        current_time;
   logic signed [31:0] resp_delay;
   logic signed [31:0] turn_delay;
   logic signed [31:0] wait_delay;
   logic               all_done;

   modport source (output valid, winner, status, current_time, resp_delay,
                   turn_delay, wait_delay, all_done, input ready);
   modport sink   (input valid, winner, status, current_time, resp_delay,
                   turn_delay, wait_delay, all_done, output ready);
endinterface

// ===== hdl/lts_datapath.sv =====
// ---------------------------------------------------------------------------
// Lottery scheduler datapath
// Slot stores, ticket walk, time accounting and the output register.
// ---------------------------------------------------------------------------
module lts_datapath #(
   parameter int MAX_PROCS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [15:0]         csr_write_data,
   input  logic                opcode,
   input  logic [2:0]          slot,
   input  logic [15:0]         arrive_at,
   input  logic [15:0]         run_length,
   input  logic [6:0]          tickets,
   input  logic [6:0]          draw,
   input  lts_pkg::cmd_type    cmd,
   output lts_pkg::sts_type    sts,
   output logic [2:0]          winner,
   output logic [2:0]          status,
   output logic [31:0]         current_time,
   output logic signed [31:0]  resp_delay,
   output logic signed [31:0]  turn_delay,
   output logic signed [31:0]  wait_delay,
   output logic                all_done
);

   localparam int NSLOT = (MAX_PROCS < lts_pkg::SLOT_LIMIT) ? MAX_PROCS : lts_pkg::SLOT_LIMIT;
   localparam int IW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
   localparam int PW    = $clog2(MAX_PROCS + 1);
   localparam int SW    = lts_pkg::TICKET_W + PW;

   logic [15:0]      arrival_store_ff   [NSLOT];
   logic [15:0]      burst_store_ff     [NSLOT];
   logic [6:0]       ticket_store_ff    [NSLOT];
   logic [15:0]      remaining_store_ff [NSLOT];
   logic [NSLOT-1:0] finished_ff;
   logic [NSLOT-1:0] started_ff;

   logic [31:0] time_ff;
   logic [15:0] slice_ff;
   logic [3:0]  count_ff;
   logic [PW-1:0] ptr_ff;
   logic [SW-1:0] sum_ff;
   logic [6:0]  draw_ff;
   logic [2:0]  winner_ff;
   logic [2:0]  status_ff;
   logic [31:0] resp_ff;
   logic [31:0] turn_ff;
   logic [31:0] wait_ff;

   logic [2:0]  out_winner_ff;
   logic [2:0]  out_status_ff;
   logic [31:0] out_time_ff;
   logic [31:0] out_resp_ff;
   logic [31:0] out_turn_ff;
   logic [31:0] out_wait_ff;
   logic        out_done_ff;

   logic [PW-1:0] n_use;
   logic          ptr_ok;
   logic [IW-1:0] idx;
   logic [IW-1:0] slot_idx;
   logic          slot_ok;
   logic [6:0]    cur_tk;
   logic [15:0]   cur_arr;
   logic [15:0]   cur_burst;
   logic [15:0]   cur_rem;
   logic          cur_fin;
   logic          cur_started;
   logic [SW-1:0] sum_in;
   logic          done_in;

   assign n_use = (32'(count_ff) > 32'(MAX_PROCS)) ? PW'(MAX_PROCS) : PW'(count_ff);
   assign ptr_ok   = 32'(ptr_ff) < 32'(NSLOT);
   assign idx      = ptr_ff[IW-1:0];
   assign slot_ok  = 32'(slot) < 32'(NSLOT);
   assign slot_idx = slot[IW-1:0];

   // slots past the store width read as empty
   assign cur_tk      = ptr_ok ? ticket_store_ff[idx]    : '0;
   assign cur_arr     = ptr_ok ? arrival_store_ff[idx]   : '0;
   assign cur_burst   = ptr_ok ? burst_store_ff[idx]     : '0;
   assign cur_rem     = ptr_ok ? remaining_store_ff[idx] : '0;
   assign cur_fin     = ptr_ok ? finished_ff[idx]        : 1'b0;
   assign cur_started = ptr_ok ? started_ff[idx]         : 1'b0;

   assign sum_in = sum_ff + SW'(cur_tk);

   always_comb begin
      done_in = 32'(n_use) <= 32'(NSLOT);
      for (int i = 0; i < NSLOT; i++) begin
         if ((32'(i) < 32'(n_use)) && !finished_ff[i]) begin
            done_in = 1'b0;
         end
      end
   end

   always_comb begin
      sts.item_draw    = opcode == lts_pkg::OP_DRAW;
      sts.ptr_end      = ptr_ff >= n_use;
      sts.walk_hit     = sum_in > SW'(draw_ff);
      sts.win_finished = cur_fin;
      sts.finishing    = cur_rem <= slice_ff;
      sts.slot_pending = !cur_fin;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff <= 16'd1;
         count_ff <= 4'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            lts_pkg::REG_TIME_SLICE:    slice_ff <= csr_write_data;
            lts_pkg::REG_PROCESS_COUNT: count_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // slot stores, no reset
   always_ff @(posedge clock) begin
      if (cmd.accept && (opcode == lts_pkg::OP_LOAD) && slot_ok) begin
         arrival_store_ff[slot_idx]   <= arrive_at;
         burst_store_ff[slot_idx]     <= run_length;
         ticket_store_ff[slot_idx]    <= tickets;
         remaining_store_ff[slot_idx] <= run_length;
      end else if (cmd.charge && !cur_fin && ptr_ok) begin
         remaining_store_ff[idx] <= (cur_rem > slice_ff) ? (cur_rem - slice_ff) : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finished_ff <= '0;
         started_ff  <= '0;
         time_ff     <= '0;
      end else if (cmd.accept) begin
         if ((opcode == lts_pkg::OP_LOAD) && slot_ok) begin
            finished_ff[slot_idx] <= 1'b0;
            started_ff[slot_idx]  <= 1'b0;
            if (slot == 3'd0) begin
               time_ff <= {16'd0, arrive_at};
            end
         end
      end else if (cmd.charge && !cur_fin) begin
         if (ptr_ok) begin
            started_ff[idx] <= 1'b1;
            if (cur_rem <= slice_ff) begin
               finished_ff[idx] <= 1'b1;
            end
         end
         time_ff <= time_ff + ((cur_rem > slice_ff) ? {16'd0, slice_ff} : {16'd0, cur_rem});
      end else if (cmd.scan_jump) begin
         // jump forward to the first unfinished arrival
         if (time_ff <= {16'd0, cur_arr}) begin
            time_ff <= {16'd0, cur_arr};
         end
      end
   end

   // walk pointer, ticket sum and per-item results
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ptr_ff    <= '0;
         sum_ff    <= '0;
         draw_ff   <= draw;
         winner_ff <= 3'd0;
         status_ff <= lts_pkg::ST_LOADED;
         resp_ff   <= '0;
         turn_ff   <= '0;
         wait_ff   <= '0;
      end else if (cmd.walk_step || cmd.scan_step) begin
         ptr_ff <= ptr_ff + PW'(1);
         sum_ff <= sum_in;
      end else if (cmd.no_winner) begin
         status_ff <= lts_pkg::ST_NO_WINNER;
      end else if (cmd.charge) begin
         winner_ff <= 3'(ptr_ff);
         if (cur_fin) begin
            status_ff <= lts_pkg::ST_WIN_DONE;
         end else begin
            if (!cur_started) begin
               resp_ff <= time_ff - {16'd0, cur_arr};
            end
            status_ff <= (cur_rem > slice_ff) ? lts_pkg::ST_SLICE_RUN : lts_pkg::ST_FINISHED;
         end
      end else if (cmd.calc_turn) begin
         turn_ff <= time_ff - {16'd0, cur_arr};
      end else if (cmd.calc_wait) begin
         wait_ff <= turn_ff - {16'd0, cur_burst};
         ptr_ff  <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_winner_ff <= winner_ff;
         out_status_ff <= status_ff;
         out_time_ff   <= time_ff;
         out_resp_ff   <= resp_ff;
         out_turn_ff   <= turn_ff;
         out_wait_ff   <= wait_ff;
         out_done_ff   <= done_in;
      end
   end

   assign winner       = out_winner_ff;
   assign status       = out_status_ff;
   assign current_time = out_time_ff;
   assign resp_delay   = out_resp_ff;
   assign turn_delay   = out_turn_ff;
   assign wait_delay   = out_wait_ff;
   assign all_done     = out_done_ff;

endmodule

// ===== hdl/lts_controller.sv =====
// ---------------------------------------------------------------------------
// Lottery scheduler controller
// Sequences load, ticket walk, charge, finish scan and result hand-off.
// ---------------------------------------------------------------------------
`include "lottery_time_slice_scheduler_macros.svh"

module lts_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  lts_pkg::sts_type sts,
   output lts_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WALK   = 3'd1;
   localparam logic [2:0] S_CHARGE = 3'd2;
   localparam logic [2:0] S_TURN   = 3'd3;
   localparam logic [2:0] S_WAIT   = 3'd4;
   localparam logic [2:0] S_SCAN   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       out_valid_ff;
   logic       out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.item_draw ? S_WALK : S_DONE;
            end
         end
         S_WALK: begin
            if (sts.ptr_end) begin
               cmd.no_winner = 1'b1;
               state_in      = S_DONE;
            end else if (sts.walk_hit) begin
               state_in = S_CHARGE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_CHARGE: begin
            cmd.charge = 1'b1;
            state_in   = (!sts.win_finished && sts.finishing) ? S_TURN : S_DONE;
         end
         S_TURN: begin
            cmd.calc_turn = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            cmd.calc_wait = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            if (sts.ptr_end) begin
               state_in = S_DONE;
            end else if (sts.slot_pending) begin
               cmd.scan_jump = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.publish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   `LTS_ASSERT_NOW(a_one_command, clock, reset, 1'b1, $onehot0(cmd))
   `LTS_ASSERT_NOW(a_publish_free, clock, reset, cmd.publish, !out_valid_ff || rsp_ready)
   `LTS_ASSERT_NEXT(a_publish_valid, clock, reset, cmd.publish, rsp_valid && state_ff == S_IDLE)
   `LTS_ASSERT_NEXT(a_draw_walks, clock, reset, req_valid && req_ready && sts.item_draw,
                    state_ff == S_WALK)
   `LTS_ASSERT_NEXT(a_finish_turn, clock, reset,
                    cmd.charge && !sts.win_finished && sts.finishing, state_ff == S_TURN)

endmodule

// ===== hdl/lottery_time_slice_scheduler.sv =====
// ---------------------------------------------------------------------------
// Lottery time-slice scheduler
// A load word is written to its slot store and goes straight to the result
// hand-off. A draw word walks the slot stores one slot per cycle until the
// ticket sum passes the draw at slot w (or finds no winner among the n slots
// in use), then charges the winner up to one time slice; if the winner
// finishes, its turnaround and waiting times follow and a forward-time scan,
// also one slot per cycle, finds the first unfinished slot u (n when every
// slot has finished). The hand-off waits while the consumer still holds the
// previous result. A result sits in an output register, so a new word is
// taken while it waits, but the controller works on one word at a time.
// ---------------------------------------------------------------------------
module lottery_time_slice_scheduler #(
   parameter int MAX_PROCS = 8
) (
   input  logic        clock,
   input  logic        reset,
   lts_req_if.sink     req_bus,
   lts_rsp_if.source   rsp_bus,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   lts_pkg::cmd_type cmd;
   lts_pkg::sts_type sts;
   logic             req_ready;
   logic             rsp_valid;

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

   lts_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lts_datapath #(
      .MAX_PROCS (MAX_PROCS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .opcode           (req_bus.opcode),
      .slot             (req_bus.slot),
      .arrive_at        (req_bus.arrive_at),
      .run_length       (req_bus.run_length),
      .tickets          (req_bus.tickets),
      .draw             (req_bus.draw),
      .cmd              (cmd),
      .sts              (sts),
      .winner           (rsp_bus.winner),
      .status           (rsp_bus.status),
      .current_time     (rsp_bus.current_time),
      .resp_delay       (rsp_bus.resp_delay),
      .turn_delay       (rsp_bus.turn_delay),
      .wait_delay       (rsp_bus.wait_delay),
      .all_done         (rsp_bus.all_done)
   );

endmodule
